### design/bfft_pkg.sv
// Shared types and constants for the bit map find-first unit.
`default_nettype none

package bfft_pkg;

  localparam int LEN_W = 11;
  localparam int IDX_W = 10;

  localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;
  localparam logic [LEN_W-1:0] COUNT_MAX = 11'd2047;

  typedef enum logic [2:0] {
    OP_WRITE,
    OP_READ,
    OP_FILL,
    OP_FIND,
    OP_LEAD,
    OP_TRAIL
  } op_e;

  typedef struct packed {
    logic [2:0]       opcode;
    logic [IDX_W-1:0] index;
    logic             bit_value;
  } in_item_t;

  typedef struct packed {
    logic             bit_read;
    logic             found;
    logic [LEN_W-1:0] position;
    logic [LEN_W-1:0] set_count;
    logic             all_set;
    logic             none_set;
    logic             range_error;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic done;
  } dp_stat_t;

endpackage

`default_nettype wire

### design/bfft_ctrl.sv
// Controller: accepts a beat, steps the word scan, hands the result to the output register.
`default_nettype none

module bfft_ctrl import bfft_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire logic      out_stall_i,
  output logic           out_valid_o,
  input  wire dp_stat_t  stat_i,
  output ctrl_cmd_t      cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    cmd_o        = '0;
    cmd_o.load   = (state_q == S_IDLE) && in_valid_i;
    cmd_o.step   = (state_q == S_EXEC) && !stat_i.done;
    cmd_o.finish = (state_q == S_EXEC) && stat_i.done && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      // hold the result until the receiver takes it
      out_valid_q <= cmd_o.finish || (out_valid_q && out_stall_i);
      case (state_q)
        S_IDLE: begin
          if (cmd_o.load) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (cmd_o.finish) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### design/bfft_dp.sv
// Datapath: bit map words, set count, length register, per-word scan and output register.
`default_nettype none

module bfft_dp import bfft_pkg::*; #(
  parameter int NUM_BITS  = 1024,
  parameter int WORD_BITS = 64
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire ctrl_cmd_t        cmd_i,
  output dp_stat_t              stat_o,
  input  wire in_item_t         in_item_i,
  input  wire logic             cfg_we_i,
  input  wire logic [LEN_W-1:0] cfg_data_i,
  output out_item_t             out_item_o
);

  localparam int NW = (NUM_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW = (NW > 1) ? $clog2(NW) : 1;
  localparam int PW = $clog2(NW * WORD_BITS + 1);
  localparam int XW = ((PW > LEN_W) ? PW : LEN_W) + 1;
  localparam int OW = $clog2(WORD_BITS + 1);
  localparam int KW = $clog2(WORD_BITS);
  localparam logic [LEN_W-1:0] LEN_MAX =
    (NUM_BITS < 2 ** LEN_W) ? LEN_W'(NUM_BITS) : '1;

  logic [LEN_W-1:0]     len_q;
  logic [LEN_W-1:0]     cnt_q, cnt_d;
  logic                 fill_q;
  logic [NW-1:0]        vld_q;
  logic [WORD_BITS-1:0] words_q [NW];
  logic [2:0]           op_q;
  logic [IDX_W-1:0]     idx_q;
  logic                 val_q;
  logic [AW-1:0]        w_q;
  logic [PW-1:0]        base_q;
  logic [XW-1:0]        pad_q;
  out_item_t            out_q, res;

  logic [LEN_W-1:0]     len_l;
  logic [XW-1:0]        base_x, len_x, idx_x, wbits_x, hi_d, lo_d;
  logic [XW-1:0]        up_pos, down_pos, lead_pos;
  logic [OW-1:0]        hi_off, lo_off;
  logic [KW-1:0]        bit_off, lsb, msb;
  logic [WORD_BITS-1:0] cur_word, new_word, pat, mask, cand;
  logic                 is_wr, is_rd, is_find, is_lead, is_trail, is_fill, is_top;
  logic                 rw_op, scan_op, err, hit, idx_ge, idx_in, last_up, last, old_bit;

  always_comb begin
    is_wr    = (op_q == OP_WRITE);
    is_rd    = (op_q == OP_READ);
    is_fill  = (op_q == OP_FILL);
    is_find  = (op_q == OP_FIND);
    is_lead  = (op_q == OP_LEAD);
    is_trail = (op_q == OP_TRAIL);
    rw_op    = is_wr || is_rd;
    scan_op  = is_find || is_lead || is_trail;

    len_l   = (len_q > LEN_MAX) ? LEN_MAX : len_q;
    base_x  = XW'(base_q);
    len_x   = XW'(len_l);
    idx_x   = XW'(idx_q);
    wbits_x = XW'(WORD_BITS);

    err = (rw_op || is_find) && (idx_x >= len_x);

    // top of the in-use window within this word
    hi_d   = len_x - base_x;
    hi_off = (len_x <= base_x) ? '0 :
             (hi_d >= wbits_x) ? OW'(WORD_BITS) : OW'(hi_d);

    // start offset within this word, only for find next
    idx_ge = (idx_x >= base_x);
    lo_d   = idx_x - base_x;
    idx_in = idx_ge && (lo_d < wbits_x);
    lo_off = '0;
    if (is_find && idx_ge) begin
      lo_off = (lo_d >= wbits_x) ? OW'(WORD_BITS) : OW'(lo_d);
    end
    bit_off = KW'(lo_d);

    cur_word = vld_q[w_q] ? words_q[w_q] : {WORD_BITS{fill_q}};
    pat      = (is_find && !val_q) ? ~cur_word : cur_word;
    for (int k = 0; k < WORD_BITS; k++) begin
      mask[k] = (OW'(k) >= lo_off) && (OW'(k) < hi_off);
    end
    cand = pat & mask;
    hit  = |cand;

    lsb = '0;
    for (int k = WORD_BITS - 1; k >= 0; k--) begin
      if (cand[k]) begin
        lsb = KW'(k);
      end
    end
    msb = '0;
    for (int k = 0; k < WORD_BITS; k++) begin
      if (cand[k]) begin
        msb = KW'(k);
      end
    end
    up_pos   = base_x + XW'(lsb);
    down_pos = len_x - XW'(1) - base_x - XW'(msb);

    // the top word in use holds bit len-1; below it the count runs on whole words,
    // so the unused bits of the top word are counted in as well
    is_top   = (base_x < len_x) && (base_x + wbits_x >= len_x);
    lead_pos = is_top ? down_pos : down_pos + pad_q;

    last_up = (w_q == AW'(NW - 1)) || (base_x + wbits_x >= len_x);
    last    = is_lead ? (w_q == '0) : last_up;

    stat_o      = '0;
    stat_o.done = err || !(scan_op || rw_op) || (scan_op && (hit || last)) ||
                  (rw_op && (idx_in || last_up));

    old_bit           = cur_word[bit_off];
    new_word          = cur_word;
    new_word[bit_off] = val_q;

    cnt_d = cnt_q;
    if (is_wr && !err) begin
      if (val_q && !old_bit && (cnt_q != COUNT_MAX)) begin
        cnt_d = cnt_q + LEN_W'(1);
      end else if (!val_q && old_bit && (cnt_q != '0)) begin
        cnt_d = cnt_q - LEN_W'(1);
      end
    end else if (is_fill) begin
      cnt_d = val_q ? len_l : '0;
    end

    res             = '0;
    res.bit_read    = is_rd && !err && old_bit;
    res.found       = is_find && !err && hit;
    res.range_error = err;
    if (is_find || is_trail) begin
      res.position = (hit && !err) ? LEN_W'(up_pos) : len_l;
    end else if (is_lead) begin
      res.position = (hit && (lead_pos < len_x)) ? LEN_W'(lead_pos) : len_l;
    end
    res.set_count = cnt_d;
    res.all_set   = (cnt_d == len_l);
    res.none_set  = (cnt_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= LEN_RESET;
      cnt_q  <= '0;
      fill_q <= 1'b0;
      vld_q  <= '0;
      pad_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        len_q <= cfg_data_i;
      end
      // hold the unused bit count of the top word when the scan leaves it
      if (cmd_i.step && is_lead && is_top) begin
        pad_q <= base_x + wbits_x - len_x;
      end
      if (cmd_i.finish) begin
        cnt_q <= cnt_d;
        // a fill drops every word back to the fill value
        if (is_fill) begin
          vld_q  <= '0;
          fill_q <= val_q;
        end else if (is_wr && !err) begin
          vld_q[w_q] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= in_item_i.opcode;
      idx_q <= in_item_i.index;
      val_q <= in_item_i.bit_value;
      if (in_item_i.opcode == OP_LEAD) begin
        w_q    <= AW'(NW - 1);
        base_q <= PW'((NW - 1) * WORD_BITS);
      end else begin
        w_q    <= '0;
        base_q <= '0;
      end
    end else if (cmd_i.step) begin
      if (is_lead) begin
        w_q    <= w_q - AW'(1);
        base_q <= base_q - PW'(WORD_BITS);
      end else begin
        w_q    <= w_q + AW'(1);
        base_q <= base_q + PW'(WORD_BITS);
      end
    end
    if (cmd_i.finish) begin
      out_q <= res;
      if (is_wr && !err) begin
        words_q[w_q] <= new_word;
      end
    end
  end

  assign out_item_o = out_q;

endmodule

`default_nettype wire

### design/bitmap_find_first_table_unit.sv
// Top level: bit map with set count, find next match and zero scans.
//
// Input channel (in_valid_i / in_stall_o / in_item_i) carries one operation per beat:
// write, read, fill, find next, leading zeros or trailing zeros. Output channel
// (out_valid_o / out_stall_i / out_item_o) returns exactly one result beat per item.
// cfg_we_i / cfg_data_i write the length in use; write it only while idle, then fill.
// Sequence: a beat is taken while idle, then the block scans the map words,
// NW = NUM_BITS / WORD_BITS rounded up (16 by default), reading one map word per cycle:
//   fill, range error and unused opcodes: done without stepping through the words
//   write and read: scan up to the word holding the bit
//   find next and trailing zeros: up to the last word in use, early out on a match
//   leading zeros: scan down from the highest map word to word 0, early out on a match
// The input is ready again the cycle after the result is loaded into the output
// register.
// A stalled result holds in the output register while the next beat is taken and
// worked on; that item waits at its last cycle until the register frees.
// Reset clears the map to zeros, the set count to zero and the length to 1024,
// with no clearing pass.
`default_nettype none

module bitmap_find_first_table_unit import bfft_pkg::*; #(
  parameter int NUM_BITS  = 1024,
  parameter int WORD_BITS = 64
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire in_item_t         in_item_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output out_item_t             out_item_o,
  input  wire logic             cfg_we_i,
  input  wire logic [LEN_W-1:0] cfg_data_i
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // sequencing: accept, step the word scan, finish into the output register
  bfft_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // map storage, count, length register and the per-word search logic
  bfft_dp #(
    .NUM_BITS  (NUM_BITS),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .in_item_i  (in_item_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .out_item_o (out_item_o)
  );

endmodule

`default_nettype wire
